// ===== rtl/bcg_pkg.sv =====
`timescale 1ns / 1ps

package bcg_pkg;

    localparam int MAX_DEGREE     = 16;
    localparam int MAX_BLOCK_BITS = 256;

    localparam int POLY_W = 16;
    localparam int DEG_W  = 5;
    localparam int LEN_W  = 9;
    localparam int IDX_W  = $clog2(MAX_DEGREE);

    // Configuration register indexes.
    localparam logic [1:0] REG_POLY   = 2'd0;
    localparam logic [1:0] REG_DEGREE = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    localparam logic [POLY_W-1:0] POLY_RESET   = 16'd3;
    localparam logic [DEG_W-1:0]  DEGREE_RESET = 5'd3;
    localparam logic [LEN_W-1:0]  LENGTH_RESET = 9'd8;

    // Effective settings handed from the register file to the CRC core.
    typedef struct packed {
        logic [POLY_W-1:0] poly;
        logic [DEG_W-1:0]  degree;
        logic [LEN_W-1:0]  length;
    } bcg_cfg_t;

    function automatic logic [DEG_W-1:0] eff_degree(input logic [DEG_W-1:0] d);
        logic [DEG_W-1:0] r;
        r = d;
        if (d == '0)
            r = DEG_W'(1);
        else if (d > DEG_W'(MAX_DEGREE))
            r = DEG_W'(MAX_DEGREE);
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] l);
        logic [LEN_W-1:0] r;
        r = l;
        if (l == '0)
            r = LEN_W'(1);
        else if (l > LEN_W'(MAX_BLOCK_BITS))
            r = LEN_W'(MAX_BLOCK_BITS);
        return r;
    endfunction

    function automatic logic [POLY_W-1:0] deg_mask(input logic [DEG_W-1:0] d);
        logic [POLY_W:0] m;
        m = ((POLY_W+1)'(1) << d) - (POLY_W+1)'(1);
        return m[POLY_W-1:0];
    endfunction

    // One shift of the division register; degree is already in range.
    function automatic logic [POLY_W-1:0] crc_shift(
        input logic [POLY_W-1:0] rem,
        input logic [POLY_W-1:0] poly,
        input logic [DEG_W-1:0]  d,
        input logic              data_bit
    );
        logic [POLY_W-1:0] mask;
        logic [DEG_W-1:0]  top;
        logic              fb;
        logic [POLY_W-1:0] r;
        mask = deg_mask(d);
        top  = d - DEG_W'(1);
        fb   = data_bit ^ rem[top[IDX_W-1:0]];
        r    = (rem << 1) & mask;
        if (fb)
            r = r ^ (poly & mask);
        return r;
    endfunction

endpackage

// ===== rtl/bcg_in_reg.sv =====
`timescale 1ns / 1ps

module bcg_in_reg (
    input  logic clk,
    input  logic rst_n,
    input  logic s_valid,
    output logic s_ready,
    input  logic s_bit,
    output logic in_valid,
    output logic in_bit,
    input  logic in_take
);

    logic valid_reg;
    logic valid_next;
    logic bit_reg;
    logic bit_next;

    // The slot frees in the same cycle that the core takes the held word.
    assign s_ready  = !valid_reg || in_take;
    assign in_valid = valid_reg;
    assign in_bit   = bit_reg;

    always_comb
    begin
        valid_next = valid_reg;
        bit_next   = bit_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
            bit_next   = s_bit;
        end
        else if (in_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

endmodule

// ===== rtl/bcg_crc_core.sv =====
`timescale 1ns / 1ps

module bcg_crc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  bcg_pkg::bcg_cfg_t cfg,
    input  logic              in_valid,
    input  logic              in_bit,
    output logic              in_take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_bit,
    output logic              out_check,
    output logic              out_last
);

    logic [bcg_pkg::POLY_W-1:0] rem_reg;
    logic [bcg_pkg::POLY_W-1:0] rem_next;
    logic [bcg_pkg::LEN_W-1:0]  pos_reg;
    logic [bcg_pkg::LEN_W-1:0]  pos_next;
    logic [bcg_pkg::DEG_W-1:0]  chk_cnt_reg;
    logic [bcg_pkg::DEG_W-1:0]  chk_cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_bit_reg;
    logic                       out_bit_next;
    logic                       out_check_reg;
    logic                       out_check_next;
    logic                       out_last_reg;
    logic                       out_last_next;

    logic                       load_ok;
    logic                       emit_chk;
    logic                       in_checks;
    logic [bcg_pkg::POLY_W-1:0] rem_step;
    logic [bcg_pkg::LEN_W-1:0]  pos_inc;
    logic                       block_done;
    logic [bcg_pkg::DEG_W-1:0]  chk_sel;

    assign load_ok   = !out_valid_reg || out_ready;
    assign in_checks = (chk_cnt_reg != '0);
    assign in_take   = in_valid && !in_checks && load_ok;
    assign emit_chk  = in_checks && load_ok;

    assign rem_step   = bcg_pkg::crc_shift(rem_reg, cfg.poly, cfg.degree, in_bit);
    assign pos_inc    = pos_reg + bcg_pkg::LEN_W'(1);
    assign block_done = (pos_inc >= cfg.length) || (pos_inc == '0);
    // Check bits leave most significant first, counting the remaining ones down.
    assign chk_sel    = chk_cnt_reg - bcg_pkg::DEG_W'(1);

    always_comb
    begin
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        chk_cnt_next   = chk_cnt_reg;
        out_bit_next   = out_bit_reg;
        out_check_next = out_check_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (in_take)
        begin
            rem_next       = rem_step;
            out_valid_next = 1'b1;
            out_bit_next   = in_bit;
            out_check_next = 1'b0;
            out_last_next  = 1'b0;
            if (block_done)
            begin
                pos_next     = '0;
                chk_cnt_next = cfg.degree;
            end
            else
            begin
                pos_next = pos_inc;
            end
        end
        else if (emit_chk)
        begin
            out_valid_next = 1'b1;
            out_bit_next   = rem_reg[chk_sel[bcg_pkg::IDX_W-1:0]];
            out_check_next = 1'b1;
            out_last_next  = (chk_cnt_reg == bcg_pkg::DEG_W'(1));
            chk_cnt_next   = chk_sel;
            if (chk_cnt_reg == bcg_pkg::DEG_W'(1))
                rem_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            pos_reg       <= '0;
            chk_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            chk_cnt_reg   <= chk_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_bit_reg   <= out_bit_next;
        out_check_reg <= out_check_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_bit   = out_bit_reg;
    assign out_check = out_check_reg;
    assign out_last  = out_last_reg;

    a_chk_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        chk_cnt_reg <= bcg_pkg::DEG_W'(bcg_pkg::MAX_DEGREE))
        else $error("check bit count beyond maximum degree");

    a_last_is_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> out_check_reg)
        else $error("end of codeword marked on a data bit");

    a_take_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> out_valid_reg && !out_check_reg)
        else $error("taken data bit did not reach the output register");

    a_rem_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_chk && chk_cnt_reg == bcg_pkg::DEG_W'(1) |=> rem_reg == '0 && chk_cnt_reg == '0)
        else $error("remainder not cleared after the final check bit");

endmodule

// ===== rtl/block_crc_codeword_generator_core.sv =====
`timescale 1ns / 1ps

// Bit-serial block CRC encoder with a programmable generator. Message bits enter one
// word per cycle on s_axis while neither check bits nor output back-pressure hold them,
// pass through the input register and then the output register, and leave on m_axis
// as data bits; after the last bit of each block of block_length bits, crc_degree check
// bits follow, most significant first, with tlast on the final one. The input pauses
// while the single output register carries check bits. A one-word input register lets the next
// bit be accepted while a result still waits to be taken. Configuration writes are
// always ready and take effect at once; a degree of 0 acts as 1, above 16 as 16, and a
// length of 0 acts as 1, above 256 as 256.
module block_crc_codeword_generator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] msg_bit, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] code_bit, [7:1] zero
    output logic [0:0]  m_axis_tuser,   // [0] is_check
    output logic        m_axis_tlast,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [bcg_pkg::POLY_W-1:0] poly_reg;
    logic [bcg_pkg::DEG_W-1:0]  degree_reg;
    logic [bcg_pkg::LEN_W-1:0]  length_reg;
    bcg_pkg::bcg_cfg_t          cfg;

    logic in_valid;
    logic in_bit;
    logic in_take;
    logic out_bit;
    logic out_check;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg   <= bcg_pkg::POLY_RESET;
            degree_reg <= bcg_pkg::DEGREE_RESET;
            length_reg <= bcg_pkg::LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bcg_pkg::REG_POLY:   poly_reg   <= cfg_data[bcg_pkg::POLY_W-1:0];
                bcg_pkg::REG_DEGREE: degree_reg <= cfg_data[bcg_pkg::DEG_W-1:0];
                bcg_pkg::REG_LENGTH: length_reg <= cfg_data[bcg_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.poly   = poly_reg;
        cfg.degree = bcg_pkg::eff_degree(degree_reg);
        cfg.length = bcg_pkg::eff_length(length_reg);
    end

    bcg_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_bit    (s_axis_tdata[0]),
        .in_valid (in_valid),
        .in_bit   (in_bit),
        .in_take  (in_take)
    );

    bcg_crc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_bit    (in_bit),
        .in_take   (in_take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_bit   (out_bit),
        .out_check (out_check),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, out_bit};
    assign m_axis_tuser = out_check;

endmodule

// ===== test/block_crc_codeword_generator_core_tb.sv =====
`timescale 1ns / 1ps

module block_crc_codeword_generator_core_tb;

    // Index 3 maps to no register; a write there must change nothing.
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic code_bit;
        logic is_check;
        logic frame_end;
    } code_word_t;

    class crc_scoreboard;
        logic [bcg_pkg::POLY_W-1:0] poly;
        logic [bcg_pkg::DEG_W-1:0]  degree;
        logic [bcg_pkg::LEN_W-1:0]  length;
        logic [15:0]                rem;
        logic [bcg_pkg::LEN_W-1:0]  pos;
        code_word_t                 codeword_q[$];
        int                         errors;

        function new();
            poly   = bcg_pkg::POLY_RESET;
            degree = bcg_pkg::DEGREE_RESET;
            length = bcg_pkg::LENGTH_RESET;
            rem    = '0;
            pos    = '0;
            errors = 0;
        endfunction

        function void note_register(logic [1:0] idx, logic [15:0] val);
            case (idx)
                bcg_pkg::REG_POLY:   poly   = val[bcg_pkg::POLY_W-1:0];
                bcg_pkg::REG_DEGREE: degree = val[bcg_pkg::DEG_W-1:0];
                bcg_pkg::REG_LENGTH: length = val[bcg_pkg::LEN_W-1:0];
                default:    ;
            endcase
        endfunction

        // Shifts one message bit through the division register and queues the
        // data word, plus the check words when the block is complete.
        function void note_message_bit(logic msg);
            int          d;
            int          l;
            int          i;
            logic [16:0] mask;
            logic        fb;
            code_word_t  w;
            d = (degree == 0) ? 1
                : ((degree > bcg_pkg::MAX_DEGREE) ? bcg_pkg::MAX_DEGREE : int'(degree));
            l = (length == 0) ? 1
                : ((length > bcg_pkg::MAX_BLOCK_BITS) ? bcg_pkg::MAX_BLOCK_BITS
                                                      : int'(length));
            mask = (17'd1 << d) - 17'd1;
            fb   = msg ^ rem[d-1];
            rem  = (rem << 1) & mask[15:0];
            if (fb)
                rem = rem ^ (poly & mask[15:0]);
            w.code_bit  = msg;
            w.is_check  = 1'b0;
            w.frame_end = 1'b0;
            codeword_q.push_back(w);
            pos = pos + 9'd1;
            if (pos >= l || pos == 0)
            begin
                for (i = 0; i < d; i++)
                begin
                    w.code_bit  = rem[d-1-i];
                    w.is_check  = 1'b1;
                    w.frame_end = (i == d - 1);
                    codeword_q.push_back(w);
                end
                rem = '0;
                pos = '0;
            end
        endfunction

        function void check_code_word(logic code_bit, logic is_check, logic frame_end);
            code_word_t w;
            if (codeword_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: bit %0b check %0b end %0b",
                             code_bit, is_check, frame_end);
                return;
            end
            w = codeword_q.pop_front();
            if (w.code_bit !== code_bit || w.is_check !== is_check
                || w.frame_end !== frame_end)
            begin
                errors++;
                if (errors <= 10)
                    $display("word mismatch: expected bit %0b check %0b end %0b, got %0b %0b %0b",
                             w.code_bit, w.is_check, w.frame_end,
                             code_bit, is_check, frame_end);
            end
        endfunction

        function int pending();
            return codeword_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'd0;

    crc_scoreboard crc;
    int            src_idle_pct = 0;
    int            dst_idle_pct = 0;
    int            hold_request = 0;

    block_crc_codeword_generator_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: checks each accepted word and stalls at random, or for a long
    // stretch when one is requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                crc.check_code_word(m_axis_tdata[0], m_axis_tuser[0], m_axis_tlast);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    // The valid is left high; the caller lowers it after its last write.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        crc.note_register(idx, val);
    endtask

    task automatic write_settings(input logic [15:0] poly, input logic [4:0] deg,
                                  input logic [8:0] len);
        write_reg(bcg_pkg::REG_POLY, poly);
        write_reg(bcg_pkg::REG_DEGREE, {11'd0, deg});
        write_reg(bcg_pkg::REG_LENGTH, {7'd0, len});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_bit(input logic msg);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, msg};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        crc.note_message_bit(msg);
    endtask

    task automatic send_run(input logic msg, input int n);
        repeat (n)
            send_bit(msg);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_random(input int n);
        repeat (n)
            send_bit(1'($urandom_range(0, 1)));
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (crc.pending() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Mostly short blocks and in-range degrees, now and then a clamped value.
    task automatic random_phase(input int n_items);
        int          sent;
        int          n;
        logic [4:0]  d;
        logic [8:0]  l;
        sent = 0;
        while (sent < n_items)
        begin
            d = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(1, 16));
            l = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                            : 9'($urandom_range(1, 24));
            write_settings(16'($urandom), d, l);
            n = $urandom_range(1, 40);
            send_random(n);
            sent += n;
            wait_drained();
        end
    endtask

    initial
    begin
        crc = new();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: all ones, then all zeros, two full blocks.
        src_idle_pct = 29;
        dst_idle_pct = 66;
        send_run(1'b1, 8);
        send_run(1'b0, 8);
        wait_drained();

        // Degree and length of zero both act as one.
        write_settings(16'hFFFF, 5'd0, 9'd0);
        send_run(1'b1, 2);
        send_run(1'b0, 1);
        wait_drained();

        // Degree above the maximum clamps; single-bit blocks.
        write_settings(16'h8005, 5'd31, 9'd1);
        send_run(1'b1, 2);
        wait_drained();

        // Start a long block, then shrink degree and length mid-block so that
        // the block closes on the next bit with the upper remainder dropped.
        write_settings(16'h1021, 5'd16, 9'd256);
        send_run(1'b1, 5);
        wait_drained();
        write_reg(REG_SPARE, 16'hFFFF);
        cfg_valid <= 1'b0;
        write_settings(16'h0013, 5'd4, 9'd3);
        send_run(1'b0, 1);
        wait_drained();

        random_phase(45);

        src_idle_pct = 66;
        dst_idle_pct = 29;
        random_phase(45);

        // No idling: one full block at the maximum degree while the receiver
        // holds off long enough to back up the input.
        src_idle_pct = 0;
        dst_idle_pct = 0;
        write_settings(16'($urandom), 5'd16, 9'd40);
        hold_request = 120;
        send_random(40);
        wait_drained();
        random_phase(45);

        repeat (20)
            @(posedge clk);
        if (crc.errors == 0 && crc.pending() == 0)
            $display("block_crc_codeword_generator_core_tb OK");
        else
            $display("block_crc_codeword_generator_core_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("block_crc_codeword_generator_core_tb NOT OK");
        $finish;
    end

endmodule
